// ===== rtl/core/ibc_pkg.sv =====
// Shared types, widths and codes for the integer stack bytecode core.
// No dependencies; the core top, issue and execute files refer to this package by scoped names.
package ibc_pkg;

  // Storage sizes.
  localparam int unsigned StackDepth = 64;
  localparam int unsigned LocalCount = 256;

  // Field widths.
  localparam int unsigned DataW      = 32;
  localparam int unsigned PcW        = 16;
  localparam int unsigned OpW        = 4;
  localparam int unsigned LiW        = 8;
  localparam int unsigned DepthW     = 7;
  localparam int unsigned FaultW     = 2;
  localparam int unsigned StackLimW  = 7;
  localparam int unsigned LocalsLimW = 9;

  // Derived widths.
  localparam int unsigned StackIdxW = $clog2(StackDepth);
  localparam int unsigned SpW       = $clog2(StackDepth + 1);
  localparam int unsigned LocalIdxW = (LocalCount > 1) ? $clog2(LocalCount) : 1;
  localparam int unsigned StkCmpW   = ((SpW > StackLimW) ? SpW : StackLimW) + 1;

  // Stream and configuration port widths.
  localparam int unsigned InDataW   = DataW + LiW + PcW;
  localparam int unsigned OutFieldW = PcW + DataW + DepthW + FaultW;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 9;

  // Reset values of the limit registers.
  localparam logic [StackLimW-1:0]  StackLimRst  = StackLimW'(64);
  localparam logic [LocalsLimW-1:0] LocalsLimRst = LocalsLimW'(256);

  typedef enum logic [OpW-1:0] {
    OpDup      = 4'd0,
    OpSwap     = 4'd1,
    OpPush     = 4'd2,
    OpLoad     = 4'd3,
    OpStore    = 4'd4,
    OpAdd      = 4'd5,
    OpMul      = 4'd6,
    OpInc      = 4'd7,
    OpNarrow   = 4'd8,
    OpGoto     = 4'd9,
    OpBranchNe = 4'd10
  } op_e;

  typedef enum logic [FaultW-1:0] {
    FaultOk    = 2'd0,
    FaultUnder = 2'd1,
    FaultOver  = 2'd2,
    FaultLocal = 2'd3
  } fault_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStackLimit  = 1'd0,
    CfgLocalsLimit = 1'd1
  } cfg_reg_e;

  // Control handed from the issue stage to the execute stage.
  typedef struct packed {
    op_e                  op;
    logic [DataW-1:0]     imm;
    logic [LiW-1:0]       li;
    logic [PcW-1:0]       tgt;
    fault_e               fault;
    logic [SpW-1:0]       sp_new;
    logic                 stk_we;
    logic [StackIdxW-1:0] stk_waddr;
    logic                 loc_we;
  } exec_ctl_t;

  // Forwarded write data captured when a read meets a write to the same entry.
  typedef struct packed {
    logic             a_hit;
    logic [DataW-1:0] a_data;
    logic             b_hit;
    logic [DataW-1:0] b_data;
    logic             l_hit;
    logic [DataW-1:0] l_data;
    logic             l_vld;
  } fwd_t;

  // Memory writes done by the execute stage in the current cycle.
  typedef struct packed {
    logic                 stk_we;
    logic [StackIdxW-1:0] stk_waddr;
    logic [DataW-1:0]     stk_wdata;
    logic                 loc_we;
    logic [LocalIdxW-1:0] loc_waddr;
    logic [DataW-1:0]     loc_wdata;
  } wr_t;

  // One result item.
  typedef struct packed {
    logic [PcW-1:0]    next_pc;
    logic [DataW-1:0]  top_value;
    logic [DepthW-1:0] stack_depth;
    fault_e            fault;
  } res_t;

endpackage

// ===== rtl/core/int_stack_bytecode_core.sv =====
// Each result item passes the issue stage register and then the output register; a
// result not yet taken holds execute back. Throughput: one item per cycle while
// results are taken, from the issue/execute pipeline around the stack
// and locals memories; same-entry reads and writes in adjacent items are forwarded.
// Reset: stack pointer, pc and local valid bits clear and the limits return to 64 and
// 256 at once; locals read as zero until written. Items are accepted right after reset.
module int_stack_bytecode_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input item stream.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ibc_pkg::InDataW-1:0]      s_axis_tdata,  // immediate, local_index, branch_target
  input  logic [ibc_pkg::OpW-1:0]          s_axis_tuser,  // operation
  // Result item stream.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ibc_pkg::OutDataW-1:0]     m_axis_tdata,  // next_pc, top_value, stack_depth,
                                                          // fault, zero padding
  // Configuration writes.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ibc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ibc_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                               fire, adv;
  logic                               s2_valid_q, s2_valid_d;
  logic                               out_valid_q, out_valid_d;
  ibc_pkg::res_t                      res, out_q;
  logic [ibc_pkg::StackLimW-1:0]      stack_limit_q;
  logic [ibc_pkg::LocalsLimW-1:0]     locals_limit_q;
  logic [1:0][ibc_pkg::StackIdxW-1:0] stk_raddr;
  logic [1:0][ibc_pkg::DataW-1:0]     stk_rdata;
  logic [ibc_pkg::LocalIdxW-1:0]      loc_raddr;
  logic [0:0][ibc_pkg::DataW-1:0]     loc_rdata;
  ibc_pkg::exec_ctl_t                 ctl;
  ibc_pkg::fwd_t                      fwd;
  ibc_pkg::wr_t                       wr;

  // Pipeline handshake: execute advances when the output register is empty or being read out.
  assign adv           = s2_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s2_valid_q || adv;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign s2_valid_d    = fire ? 1'b1 : (adv ? 1'b0 : s2_valid_q);
  assign out_valid_d   = adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(ibc_pkg::OutDataW - ibc_pkg::OutFieldW){1'b0}},
                          out_q.fault, out_q.stack_depth, out_q.top_value, out_q.next_pc};

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_limit_q  <= ibc_pkg::StackLimRst;
      locals_limit_q <= ibc_pkg::LocalsLimRst;
    end else if (cfg_valid_i) begin
      unique case (ibc_pkg::cfg_reg_e'(cfg_index_i))
        ibc_pkg::CfgStackLimit:  stack_limit_q  <= cfg_data_i[ibc_pkg::StackLimW-1:0];
        ibc_pkg::CfgLocalsLimit: locals_limit_q <= cfg_data_i[ibc_pkg::LocalsLimW-1:0];
        default: ;
      endcase
    end
  end

  ibc_issue u_issue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .op_i           (s_axis_tuser),
    .imm_i          (s_axis_tdata[ibc_pkg::DataW-1:0]),
    .li_i           (s_axis_tdata[ibc_pkg::DataW +: ibc_pkg::LiW]),
    .tgt_i          (s_axis_tdata[ibc_pkg::DataW + ibc_pkg::LiW +: ibc_pkg::PcW]),
    .stack_limit_i  (stack_limit_q),
    .locals_limit_i (locals_limit_q),
    .wr_i           (wr),
    .stk_raddr_o    (stk_raddr),
    .loc_raddr_o    (loc_raddr),
    .ctl_o          (ctl),
    .fwd_o          (fwd)
  );

  // Entries below the top of the operand stack.
  ibc_ram #(
    .Width (ibc_pkg::DataW),
    .Depth (ibc_pkg::StackDepth),
    .NumRd (2)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (wr.stk_we),
    .waddr_i (wr.stk_waddr),
    .wdata_i (wr.stk_wdata),
    .re_i    (fire),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Local variable file.
  ibc_ram #(
    .Width (ibc_pkg::DataW),
    .Depth (ibc_pkg::LocalCount),
    .NumRd (1)
  ) u_locals_ram (
    .clk_i   (clk_i),
    .we_i    (wr.loc_we),
    .waddr_i (wr.loc_waddr),
    .wdata_i (wr.loc_wdata),
    .re_i    (fire),
    .raddr_i (loc_raddr),
    .rdata_o (loc_rdata)
  );

  ibc_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl),
    .fwd_i       (fwd),
    .stk_rdata_i (stk_rdata),
    .loc_rdata_i (loc_rdata[0]),
    .wr_o        (wr),
    .res_o       (res)
  );

`ifndef NO_ASSERTIONS
  // A new item only enters execute when the previous one leaves it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s2_valid_q) |-> adv)
    else $error("issue overwrote an item still in execute");

  // An item blocked in execute stays there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !adv) |=> s2_valid_q)
    else $error("item dropped from execute");

  // Every item leaving execute shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result lost after execute");

  // Memory writes happen only while an item completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.stk_we || wr.loc_we) |-> adv)
    else $error("memory written without a completing item");
`endif

endmodule

// ===== rtl/core/ibc_ram.sv =====
// Generic synchronous RAM: one write port and NumRd registered read ports.
// No dependencies.
module ibc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned NumRd = 1,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [Width-1:0]            wdata_i,
  input  logic                        re_i,
  input  logic [NumRd-1:0][AddrW-1:0] raddr_i,
  output logic [NumRd-1:0][Width-1:0] rdata_o
);

  logic [Width-1:0]            mem_q [Depth];
  logic [NumRd-1:0][Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      for (int unsigned i = 0; i < NumRd; i++) begin
        rdata_q[i] <= mem_q[raddr_i[i]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ibc_issue.sv =====
// Issue stage: fault checks, stack pointer, memory read addresses and write forwarding.
// Depends on ibc_pkg.
module ibc_issue (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         fire_i,
  input  logic [ibc_pkg::OpW-1:0]                      op_i,
  input  logic [ibc_pkg::DataW-1:0]                    imm_i,
  input  logic [ibc_pkg::LiW-1:0]                      li_i,
  input  logic [ibc_pkg::PcW-1:0]                      tgt_i,
  input  logic [ibc_pkg::StackLimW-1:0]                stack_limit_i,
  input  logic [ibc_pkg::LocalsLimW-1:0]               locals_limit_i,
  input  ibc_pkg::wr_t                                 wr_i,
  output logic [1:0][ibc_pkg::StackIdxW-1:0]           stk_raddr_o,
  output logic [ibc_pkg::LocalIdxW-1:0]                loc_raddr_o,
  output ibc_pkg::exec_ctl_t                           ctl_o,
  output ibc_pkg::fwd_t                                fwd_o
);

  ibc_pkg::op_e      op;
  ibc_pkg::fault_e   fault;
  logic [1:0]        need;
  logic              grow, pop1, pop2, uses_local;
  logic [ibc_pkg::SpW-1:0] sp_q, sp_d;
  logic [ibc_pkg::SpW-1:0] sp_inc, sp_m1, sp_m2, sp_m3;
  logic [ibc_pkg::StkCmpW-1:0]    stk_lim_ext, stk_lim, sp_inc_ext;
  logic [ibc_pkg::LocalsLimW-1:0] loc_lim;
  logic [ibc_pkg::LocalIdxW-1:0]  li_idx;
  logic [ibc_pkg::LocalCount-1:0] loc_vld_q;
  ibc_pkg::exec_ctl_t ctl_d, ctl_q;
  ibc_pkg::fwd_t      fwd_d, fwd_q;

  assign op     = ibc_pkg::op_e'(op_i);
  assign li_idx = li_i[ibc_pkg::LocalIdxW-1:0];
  assign sp_inc = sp_q + ibc_pkg::SpW'(1);
  assign sp_m1  = sp_q - ibc_pkg::SpW'(1);
  assign sp_m2  = sp_q - ibc_pkg::SpW'(2);
  assign sp_m3  = sp_q - ibc_pkg::SpW'(3);

  // Stack demand of each operation.
  always_comb begin
    need       = 2'd0;
    grow       = 1'b0;
    pop1       = 1'b0;
    pop2       = 1'b0;
    uses_local = 1'b0;
    unique case (op)
      ibc_pkg::OpDup:      begin need = 2'd1; grow = 1'b1; end
      ibc_pkg::OpSwap:     need = 2'd2;
      ibc_pkg::OpPush:     grow = 1'b1;
      ibc_pkg::OpLoad:     begin grow = 1'b1; uses_local = 1'b1; end
      ibc_pkg::OpStore:    begin need = 2'd1; pop1 = 1'b1; uses_local = 1'b1; end
      ibc_pkg::OpAdd,
      ibc_pkg::OpMul:      begin need = 2'd2; pop1 = 1'b1; end
      ibc_pkg::OpInc:      uses_local = 1'b1;
      ibc_pkg::OpNarrow:   need = 2'd1;
      ibc_pkg::OpBranchNe: begin need = 2'd2; pop2 = 1'b1; end
      default: ;
    endcase
  end

  // Limits in force, capped at the storage size.
  assign stk_lim_ext = ibc_pkg::StkCmpW'(stack_limit_i);
  assign stk_lim     = (stk_lim_ext > ibc_pkg::StkCmpW'(ibc_pkg::StackDepth)) ?
                       ibc_pkg::StkCmpW'(ibc_pkg::StackDepth) : stk_lim_ext;
  assign sp_inc_ext  = ibc_pkg::StkCmpW'(sp_q) + ibc_pkg::StkCmpW'(1);
  assign loc_lim     = (locals_limit_i > ibc_pkg::LocalsLimW'(ibc_pkg::LocalCount)) ?
                       ibc_pkg::LocalsLimW'(ibc_pkg::LocalCount) : locals_limit_i;

  // Fault check: local index first, then underflow, then overflow.
  always_comb begin
    priority if (uses_local && (ibc_pkg::LocalsLimW'(li_i) >= loc_lim)) begin
      fault = ibc_pkg::FaultLocal;
    end else if (sp_q < ibc_pkg::SpW'(need)) begin
      fault = ibc_pkg::FaultUnder;
    end else if (grow && (sp_inc_ext > stk_lim)) begin
      fault = ibc_pkg::FaultOver;
    end else begin
      fault = ibc_pkg::FaultOk;
    end
  end

  // New depth; a faulting item leaves it alone.
  always_comb begin
    priority if (fault != ibc_pkg::FaultOk) begin
      sp_d = sp_q;
    end else if (grow) begin
      sp_d = sp_inc;
    end else if (pop1) begin
      sp_d = sp_m1;
    end else if (pop2) begin
      sp_d = sp_m2;
    end else begin
      sp_d = sp_q;
    end
  end

  // The memory holds the entries below the top; the top lives in the execute stage.
  assign stk_raddr_o[0] = sp_m2[ibc_pkg::StackIdxW-1:0];
  assign stk_raddr_o[1] = sp_m3[ibc_pkg::StackIdxW-1:0];
  assign loc_raddr_o    = li_idx;

  // Control for the execute stage. Pushes spill the old top one entry down.
  always_comb begin
    ctl_d.op        = op;
    ctl_d.imm       = imm_i;
    ctl_d.li        = li_i;
    ctl_d.tgt       = tgt_i;
    ctl_d.fault     = fault;
    ctl_d.sp_new    = sp_d;
    ctl_d.stk_we    = (fault == ibc_pkg::FaultOk) &&
                      ((op == ibc_pkg::OpDup) || (op == ibc_pkg::OpSwap) ||
                       (((op == ibc_pkg::OpPush) || (op == ibc_pkg::OpLoad)) &&
                        (sp_q != '0)));
    ctl_d.stk_waddr = (op == ibc_pkg::OpSwap) ? sp_m2[ibc_pkg::StackIdxW-1:0] :
                                                sp_m1[ibc_pkg::StackIdxW-1:0];
    ctl_d.loc_we    = (fault == ibc_pkg::FaultOk) &&
                      ((op == ibc_pkg::OpStore) || (op == ibc_pkg::OpInc));
  end

  // Forwarding: a read that meets this cycle's write to the same entry takes the new data.
  always_comb begin
    fwd_d.a_hit  = wr_i.stk_we && (wr_i.stk_waddr == stk_raddr_o[0]);
    fwd_d.a_data = wr_i.stk_wdata;
    fwd_d.b_hit  = wr_i.stk_we && (wr_i.stk_waddr == stk_raddr_o[1]);
    fwd_d.b_data = wr_i.stk_wdata;
    fwd_d.l_hit  = wr_i.loc_we && (wr_i.loc_waddr == li_idx);
    fwd_d.l_data = wr_i.loc_wdata;
    fwd_d.l_vld  = loc_vld_q[li_idx];
  end

  // Stack pointer and local valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q      <= '0;
      loc_vld_q <= '0;
    end else begin
      if (fire_i) begin
        sp_q <= sp_d;
      end
      if (wr_i.loc_we) begin
        loc_vld_q[wr_i.loc_waddr] <= 1'b1;
      end
    end
  end

  // Stage register toward execute.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      ctl_q <= ctl_d;
      fwd_q <= fwd_d;
    end
  end

  assign ctl_o = ctl_q;
  assign fwd_o = fwd_q;

endmodule

// ===== rtl/core/ibc_exec.sv =====
// Execute stage: top-of-stack and pc registers, arithmetic, branch and memory write-back.
// Depends on ibc_pkg.
module ibc_exec (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  ibc_pkg::exec_ctl_t                  ctl_i,
  input  ibc_pkg::fwd_t                       fwd_i,
  input  logic [1:0][ibc_pkg::DataW-1:0]      stk_rdata_i,
  input  logic [ibc_pkg::DataW-1:0]           loc_rdata_i,
  output ibc_pkg::wr_t                        wr_o,
  output ibc_pkg::res_t                       res_o
);

  logic [ibc_pkg::DataW-1:0] top_q, top_d, top_alu;
  logic [ibc_pkg::PcW-1:0]   pc_q, pc_d, pc_alu, pc_inc;
  logic [ibc_pkg::DataW-1:0] s_val, u_val, l_val, prod;
  logic                      ok;

  // Operands, with forwarded data taking precedence over the memory.
  assign s_val  = fwd_i.a_hit ? fwd_i.a_data : stk_rdata_i[0];
  assign u_val  = fwd_i.b_hit ? fwd_i.b_data : stk_rdata_i[1];
  assign l_val  = fwd_i.l_hit ? fwd_i.l_data : (fwd_i.l_vld ? loc_rdata_i : '0);
  assign prod   = s_val * top_q;
  assign pc_inc = pc_q + ibc_pkg::PcW'(1);
  assign ok     = (ctl_i.fault == ibc_pkg::FaultOk);

  // New top of stack and pc for each operation.
  always_comb begin
    top_alu = top_q;
    pc_alu  = pc_inc;
    unique case (ctl_i.op)
      ibc_pkg::OpSwap,
      ibc_pkg::OpStore:    top_alu = s_val;
      ibc_pkg::OpPush:     top_alu = ctl_i.imm;
      ibc_pkg::OpLoad:     top_alu = l_val;
      ibc_pkg::OpAdd:      top_alu = s_val + top_q;
      ibc_pkg::OpMul:      top_alu = prod;
      ibc_pkg::OpNarrow:   top_alu = {{(ibc_pkg::DataW-8){top_q[7]}}, top_q[7:0]};
      ibc_pkg::OpGoto:     pc_alu  = ctl_i.tgt;
      ibc_pkg::OpBranchNe: begin
        top_alu = u_val;
        if (top_q != s_val) begin
          pc_alu = ctl_i.tgt;
        end
      end
      default: ;
    endcase
  end

  assign top_d = ok ? top_alu : top_q;
  assign pc_d  = ok ? pc_alu : pc_q;

  // Write-back; the stack always spills the current top.
  always_comb begin
    wr_o.stk_we    = adv_i && ctl_i.stk_we;
    wr_o.stk_waddr = ctl_i.stk_waddr;
    wr_o.stk_wdata = top_q;
    wr_o.loc_we    = adv_i && ctl_i.loc_we;
    wr_o.loc_waddr = ctl_i.li[ibc_pkg::LocalIdxW-1:0];
    wr_o.loc_wdata = (ctl_i.op == ibc_pkg::OpInc) ? (l_val + ctl_i.imm) : top_q;
  end

  // Result item.
  always_comb begin
    res_o.next_pc     = pc_d;
    res_o.top_value   = (ctl_i.sp_new == '0) ? '0 : top_d;
    res_o.stack_depth = ibc_pkg::DepthW'(ctl_i.sp_new);
    res_o.fault       = ctl_i.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (adv_i) begin
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      top_q <= top_d;
    end
  end

endmodule
